// ===== rtl/core/tcbc_pkg.sv =====
`timescale 1ns / 1ps

package tcbc_pkg;

   localparam int CHAN_W     = 8;
   localparam int REG_W      = 24;
   localparam int COORD_W    = 10;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_FRONT_LOW  = 2'd0;
   localparam logic [1:0] REG_FRONT_HIGH = 2'd1;
   localparam logic [1:0] REG_BACK_LOW   = 2'd2;
   localparam logic [1:0] REG_BACK_HIGH  = 2'd3;

   localparam logic [REG_W-1:0] FRONT_LOW_RST  = 24'hFFFFFF;
   localparam logic [REG_W-1:0] FRONT_HIGH_RST = 24'h000000;
   localparam logic [REG_W-1:0] BACK_LOW_RST   = 24'h013C6E;
   localparam logic [REG_W-1:0] BACK_HIGH_RST  = 24'h035082;

   // Order in which the four quotients are computed.
   localparam logic [1:0] SEL_FRONT_X = 2'd0;
   localparam logic [1:0] SEL_FRONT_Y = 2'd1;
   localparam logic [1:0] SEL_BACK_X  = 2'd2;
   localparam logic [1:0] SEL_BACK_Y  = 2'd3;

   typedef struct packed {
      logic [CHAN_W-1:0] pixel_hue;
      logic [CHAN_W-1:0] pixel_sat;
      logic [CHAN_W-1:0] pixel_val;
      logic              line_end;
      logic              frame_end;
   } req_word_type;

   typedef struct packed {
      logic               found;
      logic [COORD_W-1:0] front_x;
      logic [COORD_W-1:0] front_y;
      logic [COORD_W-1:0] back_x;
      logic [COORD_W-1:0] back_y;
      logic [COORD_W-1:0] mid_x;
      logic [COORD_W-1:0] mid_y;
   } rsp_word_type;

   typedef struct packed {
      logic [REG_W-1:0] front_low;
      logic [REG_W-1:0] front_high;
      logic [REG_W-1:0] back_low;
      logic [REG_W-1:0] back_high;
   } cfg_type;

   typedef struct packed {
      logic       pix_take;
      logic       div_start;
      logic [1:0] div_sel;
      logic       quot_take;
      logic [1:0] quot_sel;
      logic       emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic both_hit;
      logic div_done;
      logic out_free;
   } dp_status_type;

   function automatic logic in_box(input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi,
                                   input logic [CHAN_W-1:0] h, input logic [CHAN_W-1:0] s,
                                   input logic [CHAN_W-1:0] v);
      logic hue_ok;
      logic sat_ok;
      logic val_ok;
      hue_ok = (lo[23:16] <= h) && (h <= hi[23:16]);
      sat_ok = (lo[15:8] <= s) && (s <= hi[15:8]);
      val_ok = (lo[7:0] <= v) && (v <= hi[7:0]);
      return hue_ok && sat_ok && val_ok;
   endfunction

endpackage

// ===== rtl/core/two_color_blob_centroid.sv =====
`timescale 1ns / 1ps
// Channel   Ports                              Word
// pixel in  req_valid, req_stall, req_data     req_word_type (hue, sat, val, line/frame end)
// result    rsp_valid, rsp_stall, rsp_data     rsp_word_type (found, centroids, midpoint)
// config    psel, penable, pwrite, paddr, ...  four 24-bit range registers at 4*i
//
// An ordinary pixel word is taken without a stall, so a line streams at one pixel per cycle.
// A frame-end word holds req_stall high until the result is emitted: one shared radix-2
// divider forms the four centroid quotients one bit per cycle, and the emit waits for a
// free output register. With a colour absent the divisions are skipped.
// A stalled result holds in the output register and only delays the next frame end.
// Reset is synchronous; it restores the range registers and clears all accumulators.

module two_color_blob_centroid #(
   parameter int MAX_WIDTH  = tcbc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = tcbc_pkg::DEF_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  tcbc_pkg::req_word_type          req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output tcbc_pkg::rsp_word_type          rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tcbc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tcbc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [tcbc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   tcbc_pkg::cfg_type       cfg;
   tcbc_pkg::ctrl_cmd_type  cmd;
   tcbc_pkg::dp_status_type status;

   tcbc_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tcbc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_frame_end (req_data.frame_end),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   tcbc_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/tcbc_regs.sv =====
`timescale 1ns / 1ps

module tcbc_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tcbc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [tcbc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [tcbc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output tcbc_pkg::cfg_type                   cfg
);

   tcbc_pkg::cfg_type cfg_ff;
   tcbc_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [1:0]        idx;
   logic [tcbc_pkg::REG_W-1:0] rd_val;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign idx    = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            tcbc_pkg::REG_FRONT_LOW:  cfg_in.front_low  = pwdata[tcbc_pkg::REG_W-1:0];
            tcbc_pkg::REG_FRONT_HIGH: cfg_in.front_high = pwdata[tcbc_pkg::REG_W-1:0];
            tcbc_pkg::REG_BACK_LOW:   cfg_in.back_low   = pwdata[tcbc_pkg::REG_W-1:0];
            tcbc_pkg::REG_BACK_HIGH:  cfg_in.back_high  = pwdata[tcbc_pkg::REG_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.front_low  <= tcbc_pkg::FRONT_LOW_RST;
         cfg_ff.front_high <= tcbc_pkg::FRONT_HIGH_RST;
         cfg_ff.back_low   <= tcbc_pkg::BACK_LOW_RST;
         cfg_ff.back_high  <= tcbc_pkg::BACK_HIGH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         tcbc_pkg::REG_FRONT_LOW:  rd_val = cfg_ff.front_low;
         tcbc_pkg::REG_FRONT_HIGH: rd_val = cfg_ff.front_high;
         tcbc_pkg::REG_BACK_LOW:   rd_val = cfg_ff.back_low;
         tcbc_pkg::REG_BACK_HIGH:  rd_val = cfg_ff.back_high;
      endcase
   end

   assign prdata = tcbc_pkg::CSR_DATA_W'(rd_val);
   assign cfg    = cfg_ff;

endmodule

// ===== rtl/core/tcbc_div.sv =====
`timescale 1ns / 1ps

module tcbc_div #(
   parameter int DVD_W = 36,
   parameter int DVS_W = 21,
   parameter int QUO_W = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [QUO_W-1:0] quotient
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] rem_in;
   logic [QUO_W-1:0] quo_ff;
   logic [QUO_W-1:0] quo_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W-1:0] dvs_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             busy_ff;
   logic             busy_in;
   logic [DVS_W:0]   shifted;
   logic [DVS_W+1:0] diff;
   logic             ge;

   // The quotient is known to fit QUO_W bits, so the dividend bits above
   // that range already form a remainder below the divisor.
   assign shifted = {rem_ff, quo_ff[QUO_W-1]};
   assign diff    = {1'b0, shifted} - (DVS_W+2)'(dvs_ff);
   assign ge      = !diff[DVS_W+1];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = DVS_W'(dividend >> QUO_W);
         quo_in  = dividend[QUO_W-1:0];
         dvs_in  = divisor;
         cnt_in  = CNT_W'(QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff && (cnt_ff != '0)) begin
         rem_in = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         quo_in = QUO_W'({quo_ff, ge});
         cnt_in = cnt_ff - 1'b1;
      end else if (busy_ff) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = busy_ff && (cnt_ff == '0);
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/tcbc_dp.sv =====
`timescale 1ns / 1ps

module tcbc_dp #(
   parameter int MAX_WIDTH  = tcbc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = tcbc_pkg::DEF_MAX_HEIGHT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tcbc_pkg::cfg_type       cfg,
   input  tcbc_pkg::req_word_type  req_data,
   input  tcbc_pkg::ctrl_cmd_type  cmd,
   output tcbc_pkg::dp_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output tcbc_pkg::rsp_word_type  rsp_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam logic [63:0] HIT_CAP = 64'(MAX_WIDTH) * 64'(MAX_HEIGHT);
   localparam logic [63:0] SX_CAP  = HIT_CAP * 64'(MAX_WIDTH - 1);
   localparam logic [63:0] SY_CAP  = HIT_CAP * 64'(MAX_HEIGHT - 1);
   localparam int HW  = $clog2(HIT_CAP + 64'd1);
   localparam int SXW = $clog2(SX_CAP + 64'd1);
   localparam int SYW = $clog2(SY_CAP + 64'd1);
   localparam int QW  = (CW > RW) ? CW : RW;
   localparam int SW  = (SXW > SYW) ? SXW : SYW;
   localparam int EW  = (QW + 1 > tcbc_pkg::COORD_W) ? QW + 1 : tcbc_pkg::COORD_W;

   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [SXW-1:0] f_sx_ff, f_sx_in, b_sx_ff, b_sx_in;
   logic [SYW-1:0] f_sy_ff, f_sy_in, b_sy_ff, b_sy_in;
   logic [HW-1:0]  f_hit_ff, f_hit_in, b_hit_ff, b_hit_in;
   logic [SXW:0]   f_sx_add, b_sx_add;
   logic [SYW:0]   f_sy_add, b_sy_add;
   logic [HW:0]    f_hit_add, b_hit_add;
   logic [SXW-1:0] f_sx_sat, b_sx_sat;
   logic [SYW-1:0] f_sy_sat, b_sy_sat;
   logic [HW-1:0]  f_hit_sat, b_hit_sat;
   logic           f_match, b_match;
   logic           both_hit;

   logic [SW-1:0]  dvd;
   logic [HW-1:0]  dvs;
   logic           div_done;
   logic [QW-1:0]  quo;
   logic [QW-1:0]  quot_ff [4];

   logic           rsp_valid_ff, rsp_valid_in;
   tcbc_pkg::rsp_word_type rsp_data_ff, rsp_data_in;
   logic [QW:0]    mid_x_sum, mid_y_sum;
   logic [EW-1:0]  fx_ext, fy_ext, bx_ext, by_ext, mx_ext, my_ext;

   assign f_match = tcbc_pkg::in_box(cfg.front_low, cfg.front_high, req_data.pixel_hue,
                                     req_data.pixel_sat, req_data.pixel_val);
   assign b_match = tcbc_pkg::in_box(cfg.back_low, cfg.back_high, req_data.pixel_hue,
                                     req_data.pixel_sat, req_data.pixel_val);

   // Saturating accumulation of positions and hit counts.
   assign f_sx_add  = (SXW+1)'(f_sx_ff) + (SXW+1)'(col_ff);
   assign f_sy_add  = (SYW+1)'(f_sy_ff) + (SYW+1)'(row_ff);
   assign f_hit_add = (HW+1)'(f_hit_ff) + (HW+1)'(1);
   assign b_sx_add  = (SXW+1)'(b_sx_ff) + (SXW+1)'(col_ff);
   assign b_sy_add  = (SYW+1)'(b_sy_ff) + (SYW+1)'(row_ff);
   assign b_hit_add = (HW+1)'(b_hit_ff) + (HW+1)'(1);

   assign f_sx_sat  = (f_sx_add > (SXW+1)'(SX_CAP)) ? SXW'(SX_CAP) : f_sx_add[SXW-1:0];
   assign f_sy_sat  = (f_sy_add > (SYW+1)'(SY_CAP)) ? SYW'(SY_CAP) : f_sy_add[SYW-1:0];
   assign f_hit_sat = (f_hit_add > (HW+1)'(HIT_CAP)) ? HW'(HIT_CAP) : f_hit_add[HW-1:0];
   assign b_sx_sat  = (b_sx_add > (SXW+1)'(SX_CAP)) ? SXW'(SX_CAP) : b_sx_add[SXW-1:0];
   assign b_sy_sat  = (b_sy_add > (SYW+1)'(SY_CAP)) ? SYW'(SY_CAP) : b_sy_add[SYW-1:0];
   assign b_hit_sat = (b_hit_add > (HW+1)'(HIT_CAP)) ? HW'(HIT_CAP) : b_hit_add[HW-1:0];

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      f_sx_in  = f_sx_ff;
      f_sy_in  = f_sy_ff;
      f_hit_in = f_hit_ff;
      b_sx_in  = b_sx_ff;
      b_sy_in  = b_sy_ff;
      b_hit_in = b_hit_ff;
      if (cmd.pix_take) begin
         if (f_match) begin
            f_sx_in  = f_sx_sat;
            f_sy_in  = f_sy_sat;
            f_hit_in = f_hit_sat;
         end
         if (b_match) begin
            b_sx_in  = b_sx_sat;
            b_sy_in  = b_sy_sat;
            b_hit_in = b_hit_sat;
         end
         priority if (req_data.frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (req_data.line_end) begin
            col_in = '0;
            if (row_ff != RW'(MAX_HEIGHT - 1)) begin
               row_in = row_ff + 1'b1;
            end
         end else if (col_ff != CW'(MAX_WIDTH - 1)) begin
            col_in = col_ff + 1'b1;
         end
      end else if (cmd.emit) begin
         f_sx_in  = '0;
         f_sy_in  = '0;
         f_hit_in = '0;
         b_sx_in  = '0;
         b_sy_in  = '0;
         b_hit_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         f_sx_ff  <= '0;
         f_sy_ff  <= '0;
         f_hit_ff <= '0;
         b_sx_ff  <= '0;
         b_sy_ff  <= '0;
         b_hit_ff <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         f_sx_ff  <= f_sx_in;
         f_sy_ff  <= f_sy_in;
         f_hit_ff <= f_hit_in;
         b_sx_ff  <= b_sx_in;
         b_sy_ff  <= b_sy_in;
         b_hit_ff <= b_hit_in;
      end
   end

   assign both_hit = (f_hit_ff != '0) && (b_hit_ff != '0);

   always_comb begin
      unique case (cmd.div_sel)
         tcbc_pkg::SEL_FRONT_X: begin
            dvd = SW'(f_sx_ff);
            dvs = f_hit_ff;
         end
         tcbc_pkg::SEL_FRONT_Y: begin
            dvd = SW'(f_sy_ff);
            dvs = f_hit_ff;
         end
         tcbc_pkg::SEL_BACK_X: begin
            dvd = SW'(b_sx_ff);
            dvs = b_hit_ff;
         end
         tcbc_pkg::SEL_BACK_Y: begin
            dvd = SW'(b_sy_ff);
            dvs = b_hit_ff;
         end
      endcase
   end

   tcbc_div #(
      .DVD_W (SW),
      .DVS_W (HW),
      .QUO_W (QW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dvs),
      .done     (div_done),
      .quotient (quo)
   );

   always_ff @(posedge clock) begin
      if (cmd.quot_take) begin
         quot_ff[cmd.quot_sel] <= quo;
      end
   end

   assign mid_x_sum = (QW+1)'(quot_ff[tcbc_pkg::SEL_FRONT_X])
                    + (QW+1)'(quot_ff[tcbc_pkg::SEL_BACK_X]);
   assign mid_y_sum = (QW+1)'(quot_ff[tcbc_pkg::SEL_FRONT_Y])
                    + (QW+1)'(quot_ff[tcbc_pkg::SEL_BACK_Y]);

   assign fx_ext = EW'(quot_ff[tcbc_pkg::SEL_FRONT_X]);
   assign fy_ext = EW'(quot_ff[tcbc_pkg::SEL_FRONT_Y]);
   assign bx_ext = EW'(quot_ff[tcbc_pkg::SEL_BACK_X]);
   assign by_ext = EW'(quot_ff[tcbc_pkg::SEL_BACK_Y]);
   assign mx_ext = EW'(mid_x_sum[QW:1]);
   assign my_ext = EW'(mid_y_sum[QW:1]);

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.emit) begin
         rsp_data_in = '0;
         if (both_hit) begin
            rsp_data_in.found   = 1'b1;
            rsp_data_in.front_x = fx_ext[tcbc_pkg::COORD_W-1:0];
            rsp_data_in.front_y = fy_ext[tcbc_pkg::COORD_W-1:0];
            rsp_data_in.back_x  = bx_ext[tcbc_pkg::COORD_W-1:0];
            rsp_data_in.back_y  = by_ext[tcbc_pkg::COORD_W-1:0];
            rsp_data_in.mid_x   = mx_ext[tcbc_pkg::COORD_W-1:0];
            rsp_data_in.mid_y   = my_ext[tcbc_pkg::COORD_W-1:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign status.both_hit = both_hit;
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/tcbc_ctrl.sv =====
`timescale 1ns / 1ps

module tcbc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_frame_end,
   output logic                    req_stall,
   input  tcbc_pkg::dp_status_type status,
   output tcbc_pkg::ctrl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CHECK  = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [1:0] sel_ff, sel_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      sel_in        = sel_ff;
      cmd.pix_take  = 1'b0;
      cmd.div_start = 1'b0;
      cmd.quot_take = 1'b0;
      cmd.emit      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.pix_take = 1'b1;
               if (req_frame_end) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            // With either colour absent there is nothing to divide.
            if (status.both_hit) begin
               cmd.div_start = 1'b1;
               sel_in        = tcbc_pkg::SEL_FRONT_X;
               state_in      = ST_DIVIDE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               cmd.quot_take = 1'b1;
               if (sel_ff == tcbc_pkg::SEL_BACK_Y) begin
                  state_in = ST_EMIT;
               end else begin
                  sel_in        = sel_ff + 2'd1;
                  cmd.div_start = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
      cmd.div_sel  = sel_in;
      cmd.quot_sel = sel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= tcbc_pkg::SEL_FRONT_X;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

// ===== rtl/core/tcbc_checker.sv =====
`timescale 1ns / 1ps

module tcbc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input tcbc_pkg::req_word_type          req_data,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input tcbc_pkg::rsp_word_type          rsp_data,
   input logic                            psel,
   input logic                            penable,
   input logic                            pwrite,
   input logic [tcbc_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [tcbc_pkg::CSR_DATA_W-1:0] pwdata,
   input logic [tcbc_pkg::CSR_DATA_W-1:0] prdata,
   input logic                            pready
);

   // A pixel inside a frame never holds up the next one.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_data.frame_end |=> !req_stall)
      else $error("pixel stream stalled inside a frame");

   // The frame-end word always starts the result computation.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.frame_end |=> req_stall)
      else $error("frame end did not stop the input");

   // A new result only appears while input is held off.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result word appeared outside the frame-end sequence");

   // Without both colours every coordinate is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> (rsp_data.front_x == '0) && (rsp_data.front_y == '0)
         && (rsp_data.back_x == '0) && (rsp_data.back_y == '0)
         && (rsp_data.mid_x == '0) && (rsp_data.mid_y == '0))
      else $error("coordinates nonzero with found clear");

   // A stalled result word stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

endmodule

bind two_color_blob_centroid tcbc_checker u_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int PERIOD       = 12;
   localparam int SETTLE       = 250;
   localparam int LONG_HOLD    = 600;
   localparam int RANDOM_ITEMS = 500;
   localparam int PHASE_ITEMS  = 100;
   localparam int SAT_LEN      = 1030;
   localparam int CFG_A_ROW    = 2;
   localparam int FRONT        = 0;
   localparam int BACK         = 1;
   localparam int REG_W        = tcbc_pkg::REG_W;
   localparam int COORD_W      = tcbc_pkg::COORD_W;

   localparam longint unsigned HIT_CAP  = 64'(tcbc_pkg::DEF_MAX_WIDTH)
                                        * 64'(tcbc_pkg::DEF_MAX_HEIGHT);
   localparam longint unsigned SUMX_CAP = HIT_CAP * 64'(tcbc_pkg::DEF_MAX_WIDTH - 1);
   localparam longint unsigned SUMY_CAP = HIT_CAP * 64'(tcbc_pkg::DEF_MAX_HEIGHT - 1);

   localparam tcbc_pkg::rsp_word_type NO_BLOB      = '0;
   localparam tcbc_pkg::rsp_word_type FRONT_AT_ONE = {1'b1, 10'd1, 50'd0};

   typedef struct {
      tcbc_pkg::req_word_type w;
      bit                     typed;
      tcbc_pkg::rsp_word_type want;
   } dir_row_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   tcbc_pkg::req_word_type              req_data;
   logic                                rsp_valid;
   logic                                rsp_stall;
   tcbc_pkg::rsp_word_type              rsp_data;
   logic                                psel;
   logic                                penable;
   logic                                pwrite;
   logic [tcbc_pkg::CSR_ADDR_W-1:0]     paddr;
   logic [tcbc_pkg::CSR_DATA_W-1:0]     pwdata;
   logic [tcbc_pkg::CSR_DATA_W-1:0]     prdata;
   logic                                pready;

   // Shadow of the block: range registers, raster position and per-colour tallies.
   tcbc_pkg::cfg_type shadow_cfg;
   int                pos_col;
   int                pos_row;
   longint unsigned   sum_x [2];
   longint unsigned   sum_y [2];
   longint unsigned   hits [2];

   tcbc_pkg::rsp_word_type pending_blobs [$];
   dir_row_type            dir_tab [$];
   int                     fail_count;
   int                     random_items_sent;
   bit                     hold_off_req;

   two_color_blob_centroid dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #(PERIOD / 2) clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic bit colour_match(input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi,
                                       input tcbc_pkg::req_word_type w);
      logic [REG_W-1:0] px;
      bit               ok;
      px = {w.pixel_hue, w.pixel_sat, w.pixel_val};
      ok = 1'b1;
      for (int k = 0; k < 3; k++) begin
         if (px[8*k +: 8] < lo[8*k +: 8] || px[8*k +: 8] > hi[8*k +: 8]) ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic longint unsigned sat_sum(input longint unsigned a, input longint unsigned b,
                                               input longint unsigned cap);
      longint unsigned r;
      r = a + b;
      return (r > cap) ? cap : r;
   endfunction

   task automatic clear_tally();
      pos_col = 0;
      pos_row = 0;
      for (int c = 0; c < 2; c++) begin
         sum_x[c] = 0;
         sum_y[c] = 0;
         hits[c]  = 0;
      end
   endtask

   task automatic track_pixel(input tcbc_pkg::req_word_type w, output bit emits,
                              output tcbc_pkg::rsp_word_type blob);
      bit              hit [2];
      longint unsigned fx;
      longint unsigned fy;
      longint unsigned bx;
      longint unsigned by;
      hit[FRONT] = colour_match(shadow_cfg.front_low, shadow_cfg.front_high, w);
      hit[BACK]  = colour_match(shadow_cfg.back_low, shadow_cfg.back_high, w);
      for (int c = 0; c < 2; c++) begin
         if (hit[c]) begin
            sum_x[c] = sat_sum(sum_x[c], 64'(pos_col), SUMX_CAP);
            sum_y[c] = sat_sum(sum_y[c], 64'(pos_row), SUMY_CAP);
            hits[c]  = sat_sum(hits[c], 64'd1, HIT_CAP);
         end
      end
      emits = 1'b0;
      blob  = '0;
      if (w.frame_end) begin
         emits = 1'b1;
         if (hits[FRONT] != 0 && hits[BACK] != 0) begin
            fx = sum_x[FRONT] / hits[FRONT];
            fy = sum_y[FRONT] / hits[FRONT];
            bx = sum_x[BACK] / hits[BACK];
            by = sum_y[BACK] / hits[BACK];
            blob.found   = 1'b1;
            blob.front_x = COORD_W'(fx);
            blob.front_y = COORD_W'(fy);
            blob.back_x  = COORD_W'(bx);
            blob.back_y  = COORD_W'(by);
            blob.mid_x   = COORD_W'((fx + bx) / 2);
            blob.mid_y   = COORD_W'((fy + by) / 2);
         end
         clear_tally();
      end else if (w.line_end) begin
         pos_col = 0;
         if (pos_row < tcbc_pkg::DEF_MAX_HEIGHT - 1) pos_row++;
      end else if (pos_col < tcbc_pkg::DEF_MAX_WIDTH - 1) begin
         pos_col++;
      end
   endtask

   task automatic check_field(input string name, input logic [COORD_W-1:0] want,
                              input logic [COORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      tcbc_pkg::rsp_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_blobs.size() == 0) begin
            $display("%0t: result word with none expected, got %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = pending_blobs.pop_front();
            check_field("found", COORD_W'(want.found), COORD_W'(rsp_data.found));
            check_field("front_x", want.front_x, rsp_data.front_x);
            check_field("front_y", want.front_y, rsp_data.front_y);
            check_field("back_x", want.back_x, rsp_data.back_x);
            check_field("back_y", want.back_y, rsp_data.back_y);
            check_field("mid_x", want.mid_x, rsp_data.mid_x);
            check_field("mid_y", want.mid_y, rsp_data.mid_y);
         end
      end
   end

   // Result side: mostly short bursts, sometimes a long hold when the sender asks for one.
   initial begin : rsp_pacing
      int r;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_stall <= 1'b0;
               repeat ($urandom_range(1, 40)) @(negedge clock);
            end else if (r < 95) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(1, 3)) @(negedge clock);
            end else begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(20, 60)) @(negedge clock);
            end
         end
      end
   end

   // All tasks below start and end at a falling edge.
   task automatic csr_access(input logic [1:0] idx, input bit wr,
                             input logic [tcbc_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [tcbc_pkg::CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic cfg_check(input logic [1:0] idx);
      logic [tcbc_pkg::CSR_DATA_W-1:0] rd;
      logic [REG_W-1:0]                want;
      case (idx)
         tcbc_pkg::REG_FRONT_LOW:  want = shadow_cfg.front_low;
         tcbc_pkg::REG_FRONT_HIGH: want = shadow_cfg.front_high;
         tcbc_pkg::REG_BACK_LOW:   want = shadow_cfg.back_low;
         default:                  want = shadow_cfg.back_high;
      endcase
      csr_access(idx, 1'b0, '0, rd);
      if (rd[REG_W-1:0] !== want) begin
         $display("%0t: register %0d expected %h got %h", $time, idx, want, rd[REG_W-1:0]);
         fail_count++;
      end
   endtask

   task automatic cfg_write(input logic [1:0] idx, input logic [REG_W-1:0] value);
      logic [tcbc_pkg::CSR_DATA_W-1:0] rd;
      // Bits above the register width are junk and must be dropped.
      csr_access(idx, 1'b1, {8'($urandom), value}, rd);
      case (idx)
         tcbc_pkg::REG_FRONT_LOW:  shadow_cfg.front_low = value;
         tcbc_pkg::REG_FRONT_HIGH: shadow_cfg.front_high = value;
         tcbc_pkg::REG_BACK_LOW:   shadow_cfg.back_low = value;
         default:                  shadow_cfg.back_high = value;
      endcase
      cfg_check(idx);
   endtask

   task automatic write_all(input logic [REG_W-1:0] fl, input logic [REG_W-1:0] fh,
                            input logic [REG_W-1:0] bl, input logic [REG_W-1:0] bh);
      cfg_write(tcbc_pkg::REG_FRONT_LOW, fl);
      cfg_write(tcbc_pkg::REG_FRONT_HIGH, fh);
      cfg_write(tcbc_pkg::REG_BACK_LOW, bl);
      cfg_write(tcbc_pkg::REG_BACK_HIGH, bh);
   endtask

   task automatic send_pixel(input tcbc_pkg::req_word_type w, input int gap, input bit typed,
                             input tcbc_pkg::rsp_word_type want);
      bit                     emits;
      tcbc_pkg::rsp_word_type blob;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall !== 1'b0);
      track_pixel(w, emits, blob);
      if (emits) pending_blobs.push_back(typed ? want : blob);
      @(negedge clock);
   endtask

   task automatic stop_stream();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   // A frame end keeps the block busy well after its word is taken, so settle before going on.
   task automatic wait_drained();
      stop_stream();
      while (pending_blobs.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic logic [REG_W-1:0] box_pick(input logic [REG_W-1:0] lo,
                                                 input logic [REG_W-1:0] hi);
      logic [REG_W-1:0] v;
      int               r;
      for (int k = 0; k < 3; k++) begin
         r = $urandom_range(0, 19);
         if (r == 0) v[8*k +: 8] = 8'h00;
         else if (r == 1) v[8*k +: 8] = 8'hFF;
         else v[8*k +: 8] = 8'($urandom_range(lo[8*k +: 8], hi[8*k +: 8]));
      end
      return v;
   endfunction

   // Most pixels land in one of the two boxes so that both colours show up in most frames.
   function automatic tcbc_pkg::req_word_type pick_pixel();
      tcbc_pkg::req_word_type w;
      int                     r;
      w = '0;
      r = $urandom_range(0, 9);
      if (r < 4)
         {w.pixel_hue, w.pixel_sat, w.pixel_val} = box_pick(shadow_cfg.front_low,
                                                            shadow_cfg.front_high);
      else if (r < 8)
         {w.pixel_hue, w.pixel_sat, w.pixel_val} = box_pick(shadow_cfg.back_low,
                                                            shadow_cfg.back_high);
      else
         {w.pixel_hue, w.pixel_sat, w.pixel_val} = REG_W'($urandom);
      return w;
   endfunction

   task automatic random_box(output logic [REG_W-1:0] lo, output logic [REG_W-1:0] hi);
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] t;
      for (int k = 0; k < 3; k++) begin
         a = 8'($urandom);
         b = 8'($urandom);
         if ($urandom_range(0, 5) == 0) begin
            a = 8'h00;
            b = 8'hFF;
         end else if ($urandom_range(0, 7) != 0 && a > b) begin
            t = a;
            a = b;
            b = t;
         end
         lo[8*k +: 8] = a;
         hi[8*k +: 8] = b;
      end
   endtask

   // A ragged frame carries line ends at random instead of a regular raster.
   task automatic run_frame(input int max_w, input int max_h);
      int                     lines;
      int                     len;
      bit                     ragged;
      bit                     quiet;
      bit                     last_line;
      tcbc_pkg::req_word_type w;
      lines  = $urandom_range(1, max_h);
      ragged = ($urandom_range(0, 5) == 0);
      quiet  = ($urandom_range(0, 3) == 0);
      for (int l = 0; l < lines; l++) begin
         len = $urandom_range(1, max_w);
         for (int p = 0; p < len; p++) begin
            w = pick_pixel();
            last_line = (p == len - 1);
            w.line_end = ragged ? ($urandom_range(0, 2) == 0) : last_line;
            if (last_line && l == lines - 1) begin
               w.frame_end = 1'b1;
               w.line_end  = $urandom_range(0, 1);
            end
            send_pixel(w, quiet ? 0 : pick_gap(), 1'b0, NO_BLOB);
            random_items_sent++;
         end
      end
   endtask

   // One frame past the size limits: a single overlong line, or many one-pixel lines.
   task automatic sat_frame(input bit tall);
      tcbc_pkg::req_word_type w;
      for (int p = 0; p < SAT_LEN; p++) begin
         w = pick_pixel();
         w.line_end  = tall;
         w.frame_end = (p == SAT_LEN - 1);
         send_pixel(w, 0, 1'b0, NO_BLOB);
      end
   endtask

   task automatic add_row(input logic [REG_W-1:0] hsv, input logic le, input logic fe,
                          input bit typed, input tcbc_pkg::rsp_word_type want);
      dir_row_type r;
      r.w     = {hsv, le, fe};
      r.typed = typed;
      r.want  = want;
      dir_tab.push_back(r);
   endtask

   initial begin : stimulus
      logic [REG_W-1:0] fl;
      logic [REG_W-1:0] fh;
      logic [REG_W-1:0] bl;
      logic [REG_W-1:0] bh;
      int               phase;
      int               start;

      req_valid         = 1'b0;
      req_data          = '0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      reset             = 1'b1;
      fail_count        = 0;
      random_items_sent = 0;
      hold_off_req      = 1'b0;
      shadow_cfg.front_low  = tcbc_pkg::FRONT_LOW_RST;
      shadow_cfg.front_high = tcbc_pkg::FRONT_HIGH_RST;
      shadow_cfg.back_low   = tcbc_pkg::BACK_LOW_RST;
      shadow_cfg.back_high  = tcbc_pkg::BACK_HIGH_RST;
      clear_tally();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      cfg_check(tcbc_pkg::REG_FRONT_LOW);
      cfg_check(tcbc_pkg::REG_FRONT_HIGH);
      cfg_check(tcbc_pkg::REG_BACK_LOW);
      cfg_check(tcbc_pkg::REG_BACK_HIGH);

      // Out of reset the front box is empty, so a frame can never report a blob.
      add_row(24'h02_46_78, 1'b0, 1'b0, 1'b0, NO_BLOB);
      add_row(24'h00_00_00, 1'b1, 1'b1, 1'b1, NO_BLOB);
      // From here front is hue 0..127 and back is hue 128..255, all else open.
      add_row(24'h00_00_00, 1'b0, 1'b0, 1'b0, NO_BLOB);
      add_row(24'hFF_FF_FF, 1'b0, 1'b0, 1'b0, NO_BLOB);
      add_row(24'h7F_80_80, 1'b1, 1'b0, 1'b0, NO_BLOB);
      add_row(24'h80_7F_7F, 1'b0, 1'b0, 1'b0, NO_BLOB);
      add_row(24'h00_FF_00, 1'b0, 1'b1, 1'b1, FRONT_AT_ONE);
      // Back colour absent.
      add_row(24'h10_20_30, 1'b0, 1'b0, 1'b0, NO_BLOB);
      add_row(24'h7F_FF_00, 1'b1, 1'b1, 1'b1, NO_BLOB);
      // Front colour absent, frame of a single pixel.
      add_row(24'hFF_00_FF, 1'b0, 1'b1, 1'b1, NO_BLOB);
      // Three lines, last word carries both line end and frame end.
      add_row(24'h20_11_22, 1'b0, 1'b0, 1'b0, NO_BLOB);
      add_row(24'hA0_33_44, 1'b1, 1'b0, 1'b0, NO_BLOB);
      add_row(24'hA0_00_00, 1'b0, 1'b0, 1'b0, NO_BLOB);
      add_row(24'h30_55_66, 1'b0, 1'b0, 1'b0, NO_BLOB);
      add_row(24'hC0_77_88, 1'b1, 1'b0, 1'b0, NO_BLOB);
      add_row(24'h40_99_AA, 1'b0, 1'b0, 1'b0, NO_BLOB);
      add_row(24'hE0_BB_CC, 1'b1, 1'b1, 1'b0, NO_BLOB);
      // The position must restart at the origin after a frame end.
      add_row(24'hFF_DD_EE, 1'b0, 1'b0, 1'b0, NO_BLOB);
      add_row(24'h00_FF_FF, 1'b0, 1'b1, 1'b0, NO_BLOB);

      foreach (dir_tab[i]) begin
         if (i == CFG_A_ROW) begin
            wait_drained();
            write_all(24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF);
         end
         send_pixel(dir_tab[i].w, pick_gap(), dir_tab[i].typed, dir_tab[i].want);
      end

      phase = 0;
      while (random_items_sent < RANDOM_ITEMS) begin
         wait_drained();
         case (phase)
            0: write_all(24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF);
            1: write_all(24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF);
            2: write_all(24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000);
            default: begin
               random_box(fl, fh);
               random_box(bl, bh);
               write_all(fl, fh, bl, bh);
            end
         endcase
         if (phase == 0) sat_frame(1'($urandom_range(0, 1)));
         // The result side freezes while frames keep coming, so the input must back up.
         if (phase == 1 || phase == 3) hold_off_req = 1'b1;
         start = random_items_sent;
         while (random_items_sent - start < PHASE_ITEMS) begin
            run_frame(10, 5);
            if ($urandom_range(0, 9) == 0) wait_drained();
         end
         phase++;
      end

      wait_drained();
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/tcbc_pkg.sv
rtl/core/tcbc_regs.sv
rtl/core/tcbc_div.sv
rtl/core/tcbc_dp.sv
rtl/core/tcbc_ctrl.sv
rtl/core/two_color_blob_centroid.sv
rtl/core/tcbc_checker.sv
sim/tb_top.sv
